// ===== hw/rtl/spq_pkg.sv =====
package spq_pkg;

  // Default number of stored entries.
  localparam int unsigned CapacityDef = 16;

  // A view shows at most this many entries, starting from the head.
  localparam int unsigned ViewLimit = 16;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_POP    = 2'd1,
    OP_REMOVE = 2'd2,
    OP_VIEW   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_e;

  // One stored entry, as it sits in the entry RAM.
  typedef struct packed {
    logic        [15:0] id;
    logic signed [15:0] prio;
  } entry_t;

endpackage

// ===== hw/rtl/sorted_priority_queue.sv =====
// Sorted priority queue. Holds up to CAPACITY entries (a 16-bit id and a
// signed 16-bit priority each) in a single-port-write RAM, kept in order from
// highest priority down, with equal priorities in arrival order. A command is
// taken on a rising edge with start high and busy low; busy then stays high
// until the command is finished. Results come out on strobe_o for exactly one
// cycle each and cannot be stalled, so the receiver must take every beat as it
// appears; last_o marks the final beat of a command. A refused or trivial
// command (full insert, insert into an empty queue, any command on an empty
// queue) is answered from the idle state and never raises busy. An insert
// walks the queue from the tail, one entry per cycle through the RAM's read
// port, until it finds its slot. Pop and remove scan from the head and then
// shift the tail down one slot per cycle. A view emits one beat per cycle for
// up to 16 entries. The RAM's one write port and its registered read set this
// one-entry-per-cycle pace.
module sorted_priority_queue
  import spq_pkg::*;
#(
  parameter int unsigned CAPACITY = CapacityDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic        [1:0]  opcode_i,
  input  logic        [15:0] task_id_i,
  input  logic signed [15:0] task_priority_i,
  output logic               strobe_o,
  output logic        [1:0]  status_o,
  output logic        [15:0] out_id_o,
  output logic signed [15:0] out_priority_o,
  output logic               last_o
);

  // Index width covers the RAM; count width also holds CAPACITY itself.
  localparam int unsigned IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned EW = $bits(entry_t);

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS,
    S_INS_HEAD,
    S_FWD,
    S_SHIFT
  } state_e;

  state_e state_q, state_d;
  logic [IW-1:0] idx_q, idx_d;
  logic [CW-1:0] count_q, count_d;
  op_e op_q, op_d;
  entry_t new_q, new_d;

  logic strobe_q, strobe_d;
  status_e status_q, status_d;
  entry_t out_q, out_d;
  logic last_q, last_d;

  // RAM port signals.
  logic          ram_we;
  logic [IW-1:0] ram_waddr;
  entry_t        ram_wdata;
  logic [IW-1:0] ram_raddr;
  logic [EW-1:0] ram_rdata;
  entry_t        rd_entry;

  // Position helpers for the entry whose data arrives this cycle.
  logic [CW-1:0] idx_inc;
  logic          at_tail;
  logic          view_end;

  assign rd_entry = entry_t'(ram_rdata);
  assign idx_inc  = CW'(idx_q) + CW'(1);
  assign at_tail  = (idx_inc == count_q);
  assign view_end = at_tail || ((32'(idx_q) + 32'd1) == 32'(ViewLimit));

  spq_ram #(
    .Width (EW),
    .Depth (CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    state_d   = state_q;
    idx_d     = idx_q;
    count_d   = count_q;
    op_d      = op_q;
    new_d     = new_q;
    strobe_d  = 1'b0;
    status_d  = status_q;
    out_d     = out_q;
    last_d    = last_q;
    ram_we    = 1'b0;
    ram_waddr = idx_q + IW'(1);
    ram_wdata = rd_entry;
    // By default the read port fetches the next entry toward the tail.
    ram_raddr = idx_q + IW'(1);

    case (state_q)
      S_IDLE: begin
        if (start) begin
          op_d  = op_e'(opcode_i);
          new_d = '{id: task_id_i, prio: task_priority_i};
          if (op_e'(opcode_i) == OP_INSERT) begin
            if (count_q == CW'(CAPACITY)) begin
              strobe_d = 1'b1;
              status_d = ST_FULL;
              out_d    = '0;
              last_d   = 1'b1;
            end else if (count_q == '0) begin
              ram_we    = 1'b1;
              ram_waddr = '0;
              ram_wdata = '{id: task_id_i, prio: task_priority_i};
              count_d   = count_q + CW'(1);
              strobe_d  = 1'b1;
              status_d  = ST_OK;
              out_d     = '0;
              last_d    = 1'b1;
            end else begin
              // Start the backward walk at the tail entry.
              ram_raddr = IW'(count_q - CW'(1));
              idx_d     = IW'(count_q - CW'(1));
              state_d   = S_INS;
            end
          end else if (count_q == '0) begin
            strobe_d = 1'b1;
            status_d = ST_EMPTY;
            out_d    = '0;
            last_d   = 1'b1;
          end else begin
            ram_raddr = '0;
            idx_d     = '0;
            state_d   = S_FWD;
          end
        end
      end

      S_INS: begin
        if (rd_entry.prio >= new_q.prio) begin
          // Found the last entry that stays ahead: the new one goes behind it.
          ram_we    = 1'b1;
          ram_wdata = new_q;
          count_d   = count_q + CW'(1);
          strobe_d  = 1'b1;
          status_d  = ST_OK;
          out_d     = '0;
          last_d    = 1'b1;
          state_d   = S_IDLE;
        end else begin
          // Move this entry one slot back and look at the one before it.
          ram_we = 1'b1;
          if (idx_q == '0) begin
            state_d = S_INS_HEAD;
          end else begin
            ram_raddr = idx_q - IW'(1);
            idx_d     = idx_q - IW'(1);
          end
        end
      end

      S_INS_HEAD: begin
        ram_we    = 1'b1;
        ram_waddr = '0;
        ram_wdata = new_q;
        count_d   = count_q + CW'(1);
        strobe_d  = 1'b1;
        status_d  = ST_OK;
        out_d     = '0;
        last_d    = 1'b1;
        state_d   = S_IDLE;
      end

      S_FWD: begin
        if (op_q == OP_VIEW) begin
          strobe_d = 1'b1;
          status_d = ST_OK;
          out_d    = rd_entry;
          last_d   = view_end;
          if (view_end) begin
            state_d = S_IDLE;
          end else begin
            idx_d = idx_q + IW'(1);
          end
        end else if (op_q == OP_POP || rd_entry.id == new_q.id) begin
          strobe_d = 1'b1;
          status_d = ST_OK;
          out_d    = rd_entry;
          last_d   = 1'b1;
          if (at_tail) begin
            count_d = count_q - CW'(1);
            state_d = S_IDLE;
          end else begin
            // Close the gap: every later entry moves one slot forward.
            idx_d   = idx_q + IW'(1);
            state_d = S_SHIFT;
          end
        end else if (at_tail) begin
          strobe_d = 1'b1;
          status_d = ST_NOT_FOUND;
          out_d    = '0;
          last_d   = 1'b1;
          state_d  = S_IDLE;
        end else begin
          idx_d = idx_q + IW'(1);
        end
      end

      S_SHIFT: begin
        ram_we    = 1'b1;
        ram_waddr = idx_q - IW'(1);
        if (at_tail) begin
          count_d = count_q - CW'(1);
          state_d = S_IDLE;
        end else begin
          idx_d = idx_q + IW'(1);
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      count_q  <= '0;
      strobe_q <= 1'b0;
      idx_q    <= '0;
      op_q     <= OP_INSERT;
      new_q    <= '0;
      status_q <= ST_OK;
      out_q    <= '0;
      last_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      strobe_q <= strobe_d;
      idx_q    <= idx_d;
      op_q     <= op_d;
      new_q    <= new_d;
      status_q <= status_d;
      out_q    <= out_d;
      last_q   <= last_d;
    end
  end

  assign busy           = (state_q != S_IDLE);
  assign strobe_o       = strobe_q;
  assign status_o       = status_q;
  assign out_id_o       = out_q.id;
  assign out_priority_o = out_q.prio;
  assign last_o         = last_q;

endmodule

// ===== hw/rtl/spq_ram.sv =====
module spq_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== tb/sv/spq_checker.sv =====
module spq_checker
  import spq_pkg::*;
#(
  parameter int unsigned CAPACITY = CapacityDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic               busy_i,
  input  logic        [1:0]  opcode_i,
  input  logic        [15:0] task_id_i,
  input  logic signed [15:0] task_priority_i,
  input  logic               strobe_i,
  input  logic        [1:0]  status_i,
  input  logic        [15:0] out_id_i,
  input  logic signed [15:0] out_priority_i,
  input  logic               last_i,
  output int                 fail_count_o,
  output int                 pending_o
);

  typedef struct packed {
    status_e            status;
    logic        [15:0] id;
    logic signed [15:0] prio;
    logic               last;
  } beat_t;

  // Shadow copy of the queue contents, head at index 0.
  logic        [15:0] held_id   [CAPACITY];
  logic signed [15:0] held_prio [CAPACITY];
  int                 held_len;

  beat_t beats_due[$];

  task automatic drop_entry(int pos);
    int i;
    for (i = pos; i < held_len - 1; i++) begin
      held_id[i]   = held_id[i + 1];
      held_prio[i] = held_prio[i + 1];
    end
    held_len--;
  endtask

  task automatic predict_command(op_e op, logic [15:0] id, logic signed [15:0] prio);
    int    i;
    int    pos;
    int    n;
    beat_t b;
    b.status = ST_OK;
    b.id     = '0;
    b.prio   = '0;
    b.last   = 1'b1;
    if (op == OP_INSERT) begin
      if (held_len >= CAPACITY) begin
        b.status = ST_FULL;
      end else begin
        // A new entry goes behind everything of equal or higher priority.
        pos = 0;
        while (pos < held_len && held_prio[pos] >= prio) pos++;
        for (i = held_len; i > pos; i--) begin
          held_id[i]   = held_id[i - 1];
          held_prio[i] = held_prio[i - 1];
        end
        held_id[pos]   = id;
        held_prio[pos] = prio;
        held_len++;
      end
      beats_due.push_back(b);
    end else if (held_len == 0) begin
      b.status = ST_EMPTY;
      beats_due.push_back(b);
    end else if (op == OP_POP) begin
      b.id   = held_id[0];
      b.prio = held_prio[0];
      drop_entry(0);
      beats_due.push_back(b);
    end else if (op == OP_REMOVE) begin
      pos = -1;
      for (i = 0; i < held_len && pos < 0; i++) begin
        if (held_id[i] == id) pos = i;
      end
      if (pos < 0) begin
        b.status = ST_NOT_FOUND;
      end else begin
        b.id   = held_id[pos];
        b.prio = held_prio[pos];
        drop_entry(pos);
      end
      beats_due.push_back(b);
    end else begin
      n = (held_len < int'(ViewLimit)) ? held_len : int'(ViewLimit);
      for (i = 0; i < n; i++) begin
        b.id   = held_id[i];
        b.prio = held_prio[i];
        b.last = (i == n - 1);
        beats_due.push_back(b);
      end
    end
  endtask

  task automatic check_beat();
    beat_t got;
    beat_t want;
    got.status = status_e'(status_i);
    got.id     = out_id_i;
    got.prio   = out_priority_i;
    got.last   = last_i;
    if (beats_due.size() == 0) begin
      fail_count_o++;
      if (fail_count_o <= 10) begin
        $display("[%0t] unexpected beat: status %0d id %h prio %0d last %b",
                 $time, got.status, got.id, got.prio, got.last);
      end
    end else begin
      want = beats_due.pop_front();
      if (got !== want) begin
        fail_count_o++;
        if (fail_count_o <= 10) begin
          $display("[%0t] beat mismatch: expected status %0d id %h prio %0d last %b",
                   $time, want.status, want.id, want.prio, want.last);
          $display("[%0t]                got      status %0d id %h prio %0d last %b",
                   $time, got.status, got.id, got.prio, got.last);
        end
      end
    end
  endtask

  // Result beats are checked before a new command is predicted, since a
  // command never produces a beat on the edge that accepts it.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_len = 0;
      beats_due.delete();
      fail_count_o = 0;
      pending_o = 0;
    end else begin
      if (strobe_i) check_beat();
      if (start_i && !busy_i) begin
        predict_command(op_e'(opcode_i), task_id_i, task_priority_i);
      end
      pending_o = beats_due.size();
    end
  end

endmodule

// ===== tb/sv/tb_sorted_priority_queue.sv =====
module tb_sorted_priority_queue;
  import spq_pkg::*;

  localparam int unsigned Capacity = CapacityDef;

  // Number of commands in the random part of the run.
  localparam int RandomItems = 92;

  // The slowest correct run is about 110 commands, each with a random gap,
  // roughly two passes over 16 entries and up to 16 result beats. The limit
  // leaves a wide margin above that.
  localparam int CycleLimit = 200000;

  typedef enum int {
    PH_GROW,
    PH_SHRINK,
    PH_MIXED
  } phase_e;

  logic               clk_i;
  logic               rst_ni;
  logic               start;
  logic               busy;
  logic        [1:0]  opcode_i;
  logic        [15:0] task_id_i;
  logic signed [15:0] task_priority_i;
  logic               strobe_o;
  logic        [1:0]  status_o;
  logic        [15:0] out_id_o;
  logic signed [15:0] out_priority_o;
  logic               last_o;

  int fail_count;
  int pending;
  int cycles = 0;

  // Gap control: runs of back-to-back commands alternate with runs of
  // random gaps, so idle cycles land on every phase of a command.
  logic no_gap_run = 1'b0;
  int   run_left = 0;

  // A small pool of ids makes removes hit stored entries and makes
  // duplicate ids common.
  logic [15:0] id_pool [8];

  sorted_priority_queue #(
    .CAPACITY(Capacity)
  ) u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .opcode_i       (opcode_i),
    .task_id_i      (task_id_i),
    .task_priority_i(task_priority_i),
    .strobe_o       (strobe_o),
    .status_o       (status_o),
    .out_id_o       (out_id_o),
    .out_priority_o (out_priority_o),
    .last_o         (last_o)
  );

  // The checker sees every command beat and every result beat, keeps its
  // own copy of the queue and compares each result against it.
  spq_checker #(
    .CAPACITY(Capacity)
  ) u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start),
    .busy_i         (busy),
    .opcode_i       (opcode_i),
    .task_id_i      (task_id_i),
    .task_priority_i(task_priority_i),
    .strobe_i       (strobe_o),
    .status_i       (status_o),
    .out_id_i       (out_id_o),
    .out_priority_i (out_priority_o),
    .last_i         (last_o),
    .fail_count_o   (fail_count),
    .pending_o      (pending)
  );

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  // Watchdog: a hung handshake or a missing result ends the run here.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("[sorted_priority_queue] ERROR");
      $finish;
    end
  end

  function automatic logic [15:0] pick_id();
    if ($urandom_range(0, 4) == 0) return 16'($urandom);
    return id_pool[$urandom_range(0, 7)];
  endfunction

  // Priorities lean toward a narrow band so that ties are frequent, with the
  // extremes and the full range mixed in.
  function automatic logic signed [15:0] pick_prio();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll == 0) return 16'sh7FFF;
    if (roll == 1) return 16'sh8000;
    if (roll < 6) return 16'($signed($urandom_range(0, 6)) - 3);
    return 16'($urandom);
  endfunction

  // Issues one command beat. It is entered and left on a falling edge. When
  // the gap is zero, start simply stays high for the next command.
  task automatic send_cmd(op_e op, logic [15:0] id, logic signed [15:0] prio);
    int gap;
    if (run_left == 0) begin
      no_gap_run = ($urandom_range(0, 3) == 0);
      run_left   = $urandom_range(5, 20);
    end
    run_left--;
    gap = no_gap_run ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      // While start is low the fields carry noise that must be ignored.
      start           <= 1'b0;
      opcode_i        <= 2'($urandom);
      task_id_i       <= 16'($urandom);
      task_priority_i <= 16'($urandom);
      repeat (gap) @(negedge clk_i);
    end
    start           <= 1'b1;
    opcode_i        <= op;
    task_id_i       <= id;
    task_priority_i <= prio;
    do @(posedge clk_i); while (busy);
    @(negedge clk_i);
  endtask

  initial begin
    phase_e phase_kind;
    int     phase_left;
    int     sent;
    int     roll;
    op_e    op;

    rst_ni          = 1'b0;
    start           = 1'b0;
    opcode_i        = OP_INSERT;
    task_id_i       = '0;
    task_priority_i = '0;
    for (int i = 0; i < 8; i++) id_pool[i] = 16'($urandom);

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Pop, remove and view on an empty queue report empty.
    send_cmd(OP_POP,    16'h0000, 16'sd0);
    send_cmd(OP_REMOVE, 16'hFFFF, 16'sd0);
    send_cmd(OP_VIEW,   16'h0000, 16'sd0);

    // Extreme ids and priorities, ties kept in arrival order, and a
    // duplicate id that lands ahead of its older twin.
    send_cmd(OP_INSERT, 16'h0000, 16'sh8000);
    send_cmd(OP_INSERT, 16'hFFFF, 16'sh7FFF);
    send_cmd(OP_INSERT, 16'h1234, 16'sd0);
    send_cmd(OP_INSERT, 16'h0042, 16'sd0);
    send_cmd(OP_INSERT, 16'h00A5, -16'sd1);
    send_cmd(OP_INSERT, 16'h1234, 16'sh7FFF);
    send_cmd(OP_VIEW,   16'h0000, 16'sd0);

    // Remove of an absent id, remove of a duplicate id (first one goes),
    // pop of the head and remove of the tail.
    send_cmd(OP_REMOVE, 16'hAAAA, 16'sd0);
    send_cmd(OP_REMOVE, 16'h1234, 16'sd0);
    send_cmd(OP_POP,    16'h0000, 16'sd0);
    send_cmd(OP_REMOVE, 16'h0000, 16'sd0);
    send_cmd(OP_VIEW,   16'h0000, 16'sd0);

    // Drain to empty and pop once more.
    repeat (4) send_cmd(OP_POP, 16'h0000, 16'sd0);

    // Random part in phases. The first phase leans on inserts to grow the queue
    // from empty toward full, so full inserts and a full-length view are likely.
    phase_kind = PH_GROW;
    phase_left = 22;
    for (sent = 0; sent < RandomItems; sent++) begin
      if (phase_left == 0) begin
        phase_kind = phase_e'($urandom_range(0, 2));
        phase_left = $urandom_range(8, 24);
      end
      phase_left--;
      roll = $urandom_range(0, 99);
      case (phase_kind)
        PH_GROW: begin
          op = (roll < 80) ? OP_INSERT : op_e'($urandom_range(1, 3));
        end
        PH_SHRINK: begin
          if (roll < 15)      op = OP_INSERT;
          else if (roll < 50) op = OP_POP;
          else if (roll < 85) op = OP_REMOVE;
          else                op = OP_VIEW;
        end
        default: begin
          op = op_e'($urandom_range(0, 3));
        end
      endcase
      send_cmd(op, pick_id(), pick_prio());
    end
    start <= 1'b0;

    // Wait for the outstanding result beats, then a few more command
    // lengths to catch any stray beat.
    while (pending != 0) @(negedge clk_i);
    repeat (3 * Capacity + 8) @(negedge clk_i);

    if (fail_count == 0 && pending == 0) begin
      $display("[sorted_priority_queue] OK");
    end else begin
      $display("[sorted_priority_queue] ERROR");
    end
    $finish;
  end

endmodule
